// ===== rtl/bat_pkg.sv =====
// shared constants and types for the block average temperature converter
`timescale 1ns / 1ps

package bat_pkg;

	// samples per block, a power of two so the average is a shift
	localparam int SAMPLES = 16;

	localparam int SAMPLE_W = 10;
	localparam int COUNT_W  = 8;
	localparam int SUM_W    = 18;

	// q16 coefficients, but the fahrenheit offset is in 1/256 degree
	localparam int C_GAIN_Q16   = 16106;
	localparam int C_OFFSET_Q16 = 1344327;
	localparam int F_GAIN_Q16   = 117965;
	localparam int F_OFFSET_FIX = 8192;

	localparam int CELSIUS_Q16_W = 25;
	localparam int F_PROD_W      = 34;

	// one finished result
	typedef struct packed {
		logic signed [9:0]  fahrenheit_whole;
		logic signed [8:0]  celsius_whole;
		logic signed [17:0] fahrenheit_fixed;
		logic signed [16:0] celsius_fixed;
		logic [9:0]         average;
	} bat_result_t;

endpackage

// ===== rtl/bat_conv.sv =====
// pipelined average to celsius and fahrenheit conversion with output register
`timescale 1ns / 1ps

module bat_conv
	import bat_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                avg_valid,
	output logic                avg_ready,
	input  logic [SAMPLE_W-1:0] avg,
	output logic                res_valid,
	input  logic                res_ready,
	output bat_result_t         res
);

	logic v_s2, v_s3, v_s4, v_s5;
	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic [SAMPLE_W-1:0]                avg_s2, avg_s3, avg_s4;
	logic signed [CELSIUS_Q16_W-1:0]    c16_s2;
	logic signed [16:0]                 cfix_s3, cfix_s4;
	logic signed [F_PROD_W-1:0]         fprod_s4;
	bat_result_t                        res_s5;

	logic [23:0]                        c_mul;
	logic signed [CELSIUS_Q16_W-1:0]    c16;
	logic signed [CELSIUS_Q16_W-1:0]    c_round;
	logic signed [F_PROD_W-1:0]         f_round;
	logic signed [17:0]                 ffix;
	logic signed [16:0]                 c_trunc;
	logic signed [17:0]                 f_trunc;

	// stage handshake: a stage takes a request when empty or draining
	assign rdy_s5    = !v_s5 || res_ready;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign avg_ready = rdy_s2;

	// celsius in q16
	assign c_mul = 24'(avg) * 24'(C_GAIN_Q16);
	assign c16   = $signed({1'b0, c_mul}) - CELSIUS_Q16_W'(C_OFFSET_Q16);

	// round to 1/256 degree, ties up
	assign c_round = c16_s2 + CELSIUS_Q16_W'(128);

	// fahrenheit rounding and offset
	assign f_round = fprod_s4 + F_PROD_W'(32768);
	assign ffix    = $signed(f_round[33:16]) + 18'(F_OFFSET_FIX);

	// whole degrees truncated toward zero
	assign c_trunc = cfix_s4[16] ? cfix_s4 + 17'sd255 : cfix_s4;
	assign f_trunc = ffix[17] ? ffix + 18'sd255 : ffix;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= avg_valid;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			avg_s2 <= avg;
			c16_s2 <= c16;
		end
		if (rdy_s3) begin
			avg_s3  <= avg_s2;
			cfix_s3 <= c_round[24:8];
		end
		if (rdy_s4) begin
			avg_s4   <= avg_s3;
			cfix_s4  <= cfix_s3;
			fprod_s4 <= F_PROD_W'(cfix_s3) * F_PROD_W'(F_GAIN_Q16);
		end
		if (rdy_s5) begin
			res_s5.average          <= avg_s4;
			res_s5.celsius_fixed    <= cfix_s4;
			res_s5.fahrenheit_fixed <= ffix;
			res_s5.celsius_whole    <= c_trunc[16:8];
			res_s5.fahrenheit_whole <= f_trunc[17:8];
		end
	end

	assign res_valid = v_s5;
	assign res       = res_s5;

endmodule

// ===== rtl/block_average_temperature_converter.sv =====
// block averaging of adc samples with conversion to celsius and fahrenheit
//
// channel  dir  tdata fields (low bit up)                           tuser/tlast
// s_axis   in   sample[9:0], zero pad to 16                          none
// m_axis   out  average[9:0], celsius_fixed[26:10],                  none
//               fahrenheit_fixed[44:27], celsius_whole[53:45],
//               fahrenheit_whole[63:54]
//
// one sample request is taken every cycle while the output path can move
// a block yields a result only when its average differs from the last stored average
// the conversion path holds four stages: celsius product, rounding,
// fahrenheit product and output register
// a stall on m_axis fills the stages and then drops s_axis_tready
// arst_n clears count, sum, last average and all stage valids
`timescale 1ns / 1ps

module block_average_temperature_converter
	import bat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // sample[9:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // average, celsius_fixed, fahrenheit_fixed,
	                                    // celsius_whole, fahrenheit_whole
);

	logic [COUNT_W-1:0]  count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] last_avg_q;
	logic                v_s1;
	logic [SAMPLE_W-1:0] avg_s1;

	logic                in_acc;
	logic                conv_ready;
	logic                block_done;
	logic [SUM_W:0]      block_sum;
	logic [SAMPLE_W-1:0] block_avg;
	logic                emit;
	logic [SAMPLE_W-1:0] sample;
	bat_result_t         res;

	assign sample        = s_axis_tdata[SAMPLE_W-1:0];
	assign s_axis_tready = !v_s1 || conv_ready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// block close and truncated average
	assign block_done = (count_q == COUNT_W'(SAMPLES - 1));
	assign block_sum  = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(sample);
	assign block_avg  = SAMPLE_W'(block_sum / SAMPLES);
	assign emit       = in_acc && block_done && (block_avg != last_avg_q);

	// running sum, count and last average
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			sum_q      <= '0;
			last_avg_q <= '0;
		end else if (in_acc) begin
			if (block_done) begin
				count_q <= '0;
				sum_q   <= '0;
				if (emit) last_avg_q <= block_avg;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= block_sum[SUM_W-1:0];
			end
		end
	end

	// new average stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (emit) begin
			v_s1 <= 1'b1;
		end else if (conv_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) avg_s1 <= block_avg;
	end

	// temperature conversion
	bat_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.avg_valid (v_s1),
		.avg_ready (conv_ready),
		.avg       (avg_s1),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = res;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(SAMPLES - 1))
		else $error("sample count past block length");

	a_block_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && block_done |=> count_q == '0 && sum_q == '0)
		else $error("block close did not clear sum and count");

	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(last_avg_q))
		else $error("last average changed without a sample request");

	a_s1_matches_last: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> avg_s1 == last_avg_q)
		else $error("pending average differs from stored average");

endmodule

// ===== tb/block_average_temperature_converter_tb.sv =====
// self-checking testbench for the block average temperature converter
`timescale 1ns / 1ps

module block_average_temperature_converter_tb;
	import bat_pkg::*;

	// conversion constants, q16 gains, a q16 celsius offset and a 1/256 degree fahrenheit offset
	localparam longint DEGC_PER_CODE_Q16 = 16106;
	localparam longint DEGC_AT_ZERO_Q16  = 1344327;
	localparam longint DEGF_PER_DEGC_Q16 = 117965;
	localparam longint FREEZING_F_FIX    = 8192;

	localparam int RANDOM_PER_PHASE = 432;
	localparam int MAX_REPORTS      = 10;
	localparam int DRAIN_CYCLES     = 20;

	typedef enum {ROW_PREDICTED, ROW_NO_RESULT, ROW_TYPED} row_kind_t;

	// one directed block: samples alternate lo, hi; stray bits go above the sample
	typedef struct {
		logic [9:0]  lo;
		logic [9:0]  hi;
		logic [5:0]  stray;
		row_kind_t   kind;
		bat_result_t typed;
	} block_row_t;

	localparam bat_result_t HOT_RESULT = '{fahrenheit_whole: 10'sd447,
		celsius_whole: 9'sd230, fahrenheit_fixed: 18'sd114590,
		celsius_fixed: 17'sd59110, average: 10'd1023};
	localparam bat_result_t COLD_RESULT = '{fahrenheit_whole: -10'sd4,
		celsius_whole: -9'sd20, fahrenheit_fixed: -18'sd1260,
		celsius_fixed: -17'sd5251, average: 10'd0};

	localparam int NUM_ROWS = 13;
	block_row_t directed_blocks [0:NUM_ROWS-1] = '{
		'{10'd0,    10'd0,    6'h00, ROW_NO_RESULT, '0},          // first block zero
		'{10'd1023, 10'd1023, 6'h00, ROW_TYPED,     HOT_RESULT},
		'{10'd1023, 10'd1023, 6'h3f, ROW_NO_RESULT, '0},          // unchanged average
		'{10'd0,    10'd0,    6'h00, ROW_TYPED,     COLD_RESULT},
		'{10'd0,    10'd1,    6'h2a, ROW_NO_RESULT, '0},          // truncates to zero
		'{10'd0,    10'd1023, 6'h15, ROW_PREDICTED, '0},
		'{10'd511,  10'd512,  6'h00, ROW_NO_RESULT, '0},          // same 511 again
		'{10'd83,   10'd83,   6'h00, ROW_PREDICTED, '0},          // just below 0 c
		'{10'd84,   10'd84,   6'h00, ROW_PREDICTED, '0},          // just above 0 c
		'{10'd1,    10'd2,    6'h3f, ROW_PREDICTED, '0},
		'{10'd1022, 10'd1023, 6'h00, ROW_PREDICTED, '0},
		'{10'd1023, 10'd1023, 6'h3f, ROW_TYPED,     HOT_RESULT},
		'{10'd340,  10'd341,  6'h00, ROW_PREDICTED, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;

	// predictor state
	int          block_fill;
	logic [17:0] block_sum;
	logic [9:0]  stored_average;

	bat_result_t pending_results[$];
	int          mismatches;
	int          send_idle_pct;
	int          recv_idle_pct;

	block_average_temperature_converter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// accumulate one sample, return 1 with the converted reading when the average moves
	function automatic bit average_and_convert(input logic [9:0] sample,
			output bat_result_t reading);
		longint avg_l, c_q16, c_fix, f_fix;
		logic [9:0] avg;
		reading = '0;
		if (block_fill < SAMPLES - 1) begin
			block_fill++;
			block_sum = block_sum + sample;
			return 1'b0;
		end
		avg = 10'((block_sum + sample) / SAMPLES);
		block_sum = '0;
		block_fill = 0;
		if (avg == stored_average)
			return 1'b0;
		stored_average = avg;
		avg_l = longint'(avg);
		c_q16 = DEGC_PER_CODE_Q16 * avg_l - DEGC_AT_ZERO_Q16;
		// arithmetic shifts floor, so this rounds half up
		c_fix = (c_q16 + 128) >>> 8;
		f_fix = ((c_fix * DEGF_PER_DEGC_Q16 + 32768) >>> 16) + FREEZING_F_FIX;
		reading.average          = avg;
		reading.celsius_fixed    = c_fix[16:0];
		reading.fahrenheit_fixed = f_fix[17:0];
		reading.celsius_whole    = 9'(c_fix / 256);
		reading.fahrenheit_whole = 10'(f_fix / 256);
		return 1'b1;
	endfunction

	// drive one sample request, with random idle cycles in front
	task automatic send_sample(input logic [15:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
	endtask

	// send one sample and queue what the predictor or the table says
	task automatic apply_sample(input logic [15:0] word, input row_kind_t kind,
			input bat_result_t typed, input bit closes_block);
		bat_result_t predicted;
		bit emits;
		send_sample(word);
		emits = average_and_convert(word[9:0], predicted);
		if (kind == ROW_PREDICTED) begin
			if (emits)
				pending_results.push_back(predicted);
		end else if (kind == ROW_TYPED && closes_block) begin
			pending_results.push_back(typed);
		end
	endtask

	// random receiver stalls and result check
	always @(posedge clk) begin
		bat_result_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = bat_result_t'(m_axis_tdata);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t unexpected result: avg %0d c %0d f %0d", $realtime,
						got.average, got.celsius_fixed, got.fahrenheit_fixed);
			end else begin
				want = pending_results.pop_front();
				if (got.average !== want.average
						|| got.celsius_fixed !== want.celsius_fixed
						|| got.fahrenheit_fixed !== want.fahrenheit_fixed
						|| got.celsius_whole !== want.celsius_whole
						|| got.fahrenheit_whole !== want.fahrenheit_whole) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t result differs", $realtime);
						$display("  expected avg %0d c %0d f %0d cw %0d fw %0d",
							want.average, want.celsius_fixed, want.fahrenheit_fixed,
							want.celsius_whole, want.fahrenheit_whole);
						$display("  actual   avg %0d c %0d f %0d cw %0d fw %0d",
							got.average, got.celsius_fixed, got.fahrenheit_fixed,
							got.celsius_whole, got.fahrenheit_whole);
					end
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// main sequence
	initial begin
		logic [9:0]  target;
		logic [5:0]  stray;
		logic [9:0]  sample;
		int          mode;
		int          shifted;
		int          sent;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		arst_n         = 1'b0;
		block_fill     = 0;
		block_sum      = '0;
		stored_average = '0;
		mismatches     = 0;
		send_idle_pct  = 15;
		recv_idle_pct  = 55;
		target         = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed blocks
		foreach (directed_blocks[r]) begin
			for (int i = 0; i < SAMPLES; i++)
				apply_sample({directed_blocks[r].stray,
					(i % 2) ? directed_blocks[r].hi : directed_blocks[r].lo},
					directed_blocks[r].kind, directed_blocks[r].typed, i == SAMPLES - 1);
		end

		// random blocks in three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 55;
				recv_idle_pct = 15;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				mode = $urandom_range(99);
				// repeat target, extreme target, new target, or pure noise
				if (mode >= 20 && mode < 35) begin
					shifted = $urandom_range(3);
					target = (shifted < 2) ? 10'(shifted) : 10'(1020 + shifted);
				end else if (mode >= 35 && mode < 75) begin
					target = 10'($urandom_range(1023));
				end
				for (int i = 0; i < SAMPLES; i++) begin
					if (mode >= 75) begin
						sample = 10'($urandom_range(1023));
					end else if (mode >= 35) begin
						shifted = int'(target) + $urandom_range(6) - 3;
						sample = (shifted < 0) ? 10'd0
							: (shifted > 1023) ? 10'd1023 : 10'(shifted);
					end else begin
						sample = target;
					end
					stray = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'd0;
					apply_sample({stray, sample}, ROW_PREDICTED, '0, 1'b0);
					sent++;
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		// drain outstanding results
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("block_average_temperature_converter: match");
		else
			$display("block_average_temperature_converter: mismatch");
		$finish;
	end

	// hang guard
	initial begin
		#5000000;
		$display("block_average_temperature_converter: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bat_pkg.sv
rtl/bat_conv.sv
rtl/block_average_temperature_converter.sv
tb/block_average_temperature_converter_tb.sv
